/* src/rrf_pkg.sv */
// Shared types and constants for the RESP request framer.
package rrf_pkg;

    localparam int CFG_W = 21;

    // configuration register indexes
    localparam logic REG_MAX_ARGUMENTS   = 1'b0;
    localparam logic REG_MAX_BULK_LENGTH = 1'b1;

    localparam logic [10:0] MAX_ARGUMENTS_RESET   = 11'd1024;
    localparam logic [20:0] MAX_BULK_LENGTH_RESET = 21'd524288;

    // protocol characters
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;

    // result kinds
    localparam logic [1:0] KIND_FRAME   = 2'd0;
    localparam logic [1:0] KIND_PAYLOAD = 2'd1;
    localparam logic [1:0] KIND_ARG_END = 2'd2;

    // record status
    localparam logic [1:0] STATUS_PENDING = 2'd0;
    localparam logic [1:0] STATUS_VALID   = 2'd1;
    localparam logic [1:0] STATUS_INVALID = 2'd2;

    // error codes
    localparam logic [3:0] ERR_NONE         = 4'd0;
    localparam logic [3:0] ERR_NO_STAR      = 4'd1;
    localparam logic [3:0] ERR_INCOMP_HDR   = 4'd2;
    localparam logic [3:0] ERR_BAD_COUNT    = 4'd3;
    localparam logic [3:0] ERR_NO_DOLLAR    = 4'd4;
    localparam logic [3:0] ERR_INCOMP_LEN   = 4'd5;
    localparam logic [3:0] ERR_BAD_LENGTH   = 4'd6;
    localparam logic [3:0] ERR_INCOMP_BULK  = 4'd7;
    localparam logic [3:0] ERR_MISSING_CRLF = 4'd8;
    localparam logic [3:0] ERR_TRAILING     = 4'd9;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       record_end;
    } in_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  data;
        logic [9:0]  arg_index;
        logic [20:0] arg_length;
        logic [1:0]  record_status;
        logic [3:0]  fault_code;
    } out_t;

endpackage

/* src/rrf_core.sv */
// Framing state machine: checks one record byte per step and registers its result.
module rrf_core #(
    parameter int ARG_LIMIT    = 1024,
    parameter int LENGTH_BOUND = 1048576
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               step_en,
    input  rrf_pkg::in_t       item,
    input  logic [10:0]        max_arguments,
    input  logic [20:0]        max_bulk_length,
    output rrf_pkg::out_t      result_reg
);

    localparam int ACC_W   = $clog2(LENGTH_BOUND + 2);
    localparam int LIM_W   = (ACC_W > rrf_pkg::CFG_W) ? ACC_W : rrf_pkg::CFG_W;
    localparam int EXT_W   = ACC_W + 4;
    localparam int AL_RAW  = $clog2(ARG_LIMIT + 1);
    localparam int ALIM_W  = (AL_RAW < 11) ? ((AL_RAW < 1) ? 1 : AL_RAW) : 11;
    localparam logic [EXT_W-1:0] ACC_SAT = EXT_W'(LENGTH_BOUND + 1);

    typedef enum logic [3:0] {
        PH_STAR,
        PH_CNT,
        PH_CNT_CR,
        PH_CNT_BAD,
        PH_CNT_BADCR,
        PH_DOLLAR,
        PH_LEN,
        PH_LEN_CR,
        PH_LEN_BAD,
        PH_LEN_BADCR,
        PH_BODY,
        PH_BODY_CR,
        PH_BODY_LF,
        PH_DONE,
        PH_ERR
    } phase_t;

    phase_t              phase_reg, phase_next;
    logic [ACC_W-1:0]    acc_reg, acc_next;
    logic                neg_reg, neg_next;
    logic                has_reg, has_next;
    logic [ALIM_W-1:0]   args_left_reg, args_left_next;
    logic [9:0]          cur_arg_reg, cur_arg_next;
    logic [ACC_W-1:0]    bulk_left_reg, bulk_left_next;
    logic [ACC_W-1:0]    bulk_held_reg, bulk_held_next;
    logic [3:0]          err_reg, err_next;
    rrf_pkg::out_t       result_next;

    logic [7:0]          c;
    logic                last;
    logic [16:0]         arg_lim_wide;
    logic [ALIM_W-1:0]   arg_lim;
    logic [LIM_W-1:0]    len_lim;
    logic [LIM_W-1:0]    num_lim;
    logic                in_len;
    logic [1:0]          scan_sub;
    logic [1:0]          scan_nsub;
    logic                scan_good;
    logic                scan_bad;
    logic                is_digit;
    logic [EXT_W-1:0]    acc_mul;
    logic [ACC_W-1:0]    scan_acc;
    logic                scan_neg;
    logic                scan_has;
    phase_t              scan_phase;
    logic [ACC_W-1:0]    bulk_dec;
    logic [ALIM_W-1:0]   args_dec;
    logic [3:0]          code;

    assign c    = item.in_byte;
    assign last = item.record_end;

    // effective limits: register value bounded by the build-time limit
    assign arg_lim_wide = ({6'd0, max_arguments} < 17'(ARG_LIMIT)) ?
                          {6'd0, max_arguments} : 17'(ARG_LIMIT);
    assign arg_lim      = ALIM_W'(arg_lim_wide);
    assign len_lim      = (LIM_W'(max_bulk_length) < LIM_W'(LENGTH_BOUND)) ?
                          LIM_W'(max_bulk_length) : LIM_W'(LENGTH_BOUND);

    assign in_len  = (phase_reg == PH_LEN) || (phase_reg == PH_LEN_CR) ||
                     (phase_reg == PH_LEN_BAD) || (phase_reg == PH_LEN_BADCR);
    assign num_lim = in_len ? len_lim : LIM_W'(arg_lim);

    assign is_digit = (c >= rrf_pkg::CH_ZERO) && (c <= rrf_pkg::CH_NINE);
    assign acc_mul  = (EXT_W'(acc_reg) << 3) + (EXT_W'(acc_reg) << 1) + EXT_W'(c[3:0]);

    assign bulk_dec = bulk_left_reg - ACC_W'(1);
    assign args_dec = args_left_reg - ALIM_W'(1);

    // number scan shared by the count and the length fields
    always_comb begin
        unique case (phase_reg)
            PH_CNT, PH_LEN:         scan_sub = 2'd0;
            PH_CNT_CR, PH_LEN_CR:   scan_sub = 2'd1;
            PH_CNT_BAD, PH_LEN_BAD: scan_sub = 2'd2;
            default:                scan_sub = 2'd3;
        endcase

        scan_acc  = acc_reg;
        scan_neg  = neg_reg;
        scan_has  = has_reg;
        scan_good = 1'b0;
        scan_bad  = 1'b0;
        scan_nsub = 2'd2;
        unique case (scan_sub)
            2'd0: begin
                if (is_digit) begin
                    scan_acc  = (acc_mul > ACC_SAT) ? ACC_W'(ACC_SAT) : ACC_W'(acc_mul);
                    scan_has  = 1'b1;
                    scan_nsub = 2'd0;
                end else if (c == rrf_pkg::CH_MINUS && !neg_reg && !has_reg) begin
                    scan_neg  = 1'b1;
                    scan_nsub = 2'd0;
                end else if (c == rrf_pkg::CH_CR) begin
                    scan_nsub = 2'd1;
                end
            end
            2'd1: begin
                if (c == rrf_pkg::CH_LF) begin
                    if (!has_reg || (neg_reg && acc_reg != '0) ||
                        LIM_W'(acc_reg) > num_lim) begin
                        scan_bad = 1'b1;
                    end else begin
                        scan_good = 1'b1;
                    end
                end else if (c == rrf_pkg::CH_CR) begin
                    scan_nsub = 2'd3;
                end
            end
            2'd2: begin
                if (c == rrf_pkg::CH_CR) begin
                    scan_nsub = 2'd3;
                end
            end
            default: begin
                if (c == rrf_pkg::CH_LF) begin
                    scan_bad = 1'b1;
                end else if (c == rrf_pkg::CH_CR) begin
                    scan_nsub = 2'd3;
                end
            end
        endcase

        unique case (scan_nsub)
            2'd0:    scan_phase = in_len ? PH_LEN : PH_CNT;
            2'd1:    scan_phase = in_len ? PH_LEN_CR : PH_CNT_CR;
            2'd2:    scan_phase = in_len ? PH_LEN_BAD : PH_CNT_BAD;
            default: scan_phase = in_len ? PH_LEN_BADCR : PH_CNT_BADCR;
        endcase
    end

    always_comb begin
        phase_next     = phase_reg;
        acc_next       = acc_reg;
        neg_next       = neg_reg;
        has_next       = has_reg;
        args_left_next = args_left_reg;
        cur_arg_next   = cur_arg_reg;
        bulk_left_next = bulk_left_reg;
        bulk_held_next = bulk_held_reg;
        err_next       = err_reg;
        result_next    = '0;
        code           = rrf_pkg::ERR_NONE;

        unique case (phase_reg)
            PH_ERR: begin
            end
            PH_STAR: begin
                if (c == rrf_pkg::CH_STAR) begin
                    acc_next   = '0;
                    neg_next   = 1'b0;
                    has_next   = 1'b0;
                    phase_next = PH_CNT;
                end else begin
                    err_next   = rrf_pkg::ERR_NO_STAR;
                    phase_next = PH_ERR;
                end
            end
            PH_CNT, PH_CNT_CR, PH_CNT_BAD, PH_CNT_BADCR: begin
                acc_next = scan_acc;
                neg_next = scan_neg;
                has_next = scan_has;
                if (scan_bad) begin
                    err_next   = rrf_pkg::ERR_BAD_COUNT;
                    phase_next = PH_ERR;
                end else if (scan_good) begin
                    args_left_next = ALIM_W'(acc_reg);
                    cur_arg_next   = '0;
                    phase_next     = (acc_reg == '0) ? PH_DONE : PH_DOLLAR;
                end else begin
                    phase_next = scan_phase;
                end
            end
            PH_DOLLAR: begin
                if (c == rrf_pkg::CH_DOLLAR) begin
                    acc_next   = '0;
                    neg_next   = 1'b0;
                    has_next   = 1'b0;
                    phase_next = PH_LEN;
                end else begin
                    err_next   = rrf_pkg::ERR_NO_DOLLAR;
                    phase_next = PH_ERR;
                end
            end
            PH_LEN, PH_LEN_CR, PH_LEN_BAD, PH_LEN_BADCR: begin
                acc_next = scan_acc;
                neg_next = scan_neg;
                has_next = scan_has;
                if (scan_bad) begin
                    err_next   = rrf_pkg::ERR_BAD_LENGTH;
                    phase_next = PH_ERR;
                end else if (scan_good) begin
                    bulk_held_next = acc_reg;
                    bulk_left_next = acc_reg;
                    phase_next     = (acc_reg == '0) ? PH_BODY_CR : PH_BODY;
                end else begin
                    phase_next = scan_phase;
                end
            end
            PH_BODY: begin
                result_next.kind      = rrf_pkg::KIND_PAYLOAD;
                result_next.data      = c;
                result_next.arg_index = cur_arg_reg;
                bulk_left_next        = bulk_dec;
                if (bulk_dec == '0) begin
                    phase_next = PH_BODY_CR;
                end
            end
            PH_BODY_CR: begin
                if (last) begin
                    err_next   = rrf_pkg::ERR_INCOMP_BULK;
                    phase_next = PH_ERR;
                end else if (c == rrf_pkg::CH_CR) begin
                    phase_next = PH_BODY_LF;
                end else begin
                    err_next   = rrf_pkg::ERR_MISSING_CRLF;
                    phase_next = PH_ERR;
                end
            end
            PH_BODY_LF: begin
                if (c == rrf_pkg::CH_LF) begin
                    result_next.kind       = rrf_pkg::KIND_ARG_END;
                    result_next.arg_index  = cur_arg_reg;
                    result_next.arg_length = rrf_pkg::CFG_W'(bulk_held_reg);
                    args_left_next         = args_dec;
                    cur_arg_next           = cur_arg_reg + 10'd1;
                    phase_next             = (args_dec == '0) ? PH_DONE : PH_DOLLAR;
                end else begin
                    err_next   = rrf_pkg::ERR_MISSING_CRLF;
                    phase_next = PH_ERR;
                end
            end
            PH_DONE: begin
                err_next   = rrf_pkg::ERR_TRAILING;
                phase_next = PH_ERR;
            end
            default: begin
                err_next   = rrf_pkg::ERR_TRAILING;
                phase_next = PH_ERR;
            end
        endcase

        // verdict on the last byte, then start the next record clean
        if (last) begin
            priority if (err_next != rrf_pkg::ERR_NONE) begin
                code = err_next;
            end else if (phase_next == PH_CNT || phase_next == PH_CNT_CR ||
                         phase_next == PH_CNT_BAD || phase_next == PH_CNT_BADCR) begin
                code = rrf_pkg::ERR_INCOMP_HDR;
            end else if (phase_next == PH_DOLLAR) begin
                code = rrf_pkg::ERR_NO_DOLLAR;
            end else if (phase_next == PH_LEN || phase_next == PH_LEN_CR ||
                         phase_next == PH_LEN_BAD || phase_next == PH_LEN_BADCR) begin
                code = rrf_pkg::ERR_INCOMP_LEN;
            end else if (phase_next == PH_BODY || phase_next == PH_BODY_CR ||
                         phase_next == PH_BODY_LF) begin
                code = rrf_pkg::ERR_INCOMP_BULK;
            end else if (phase_next == PH_STAR) begin
                code = rrf_pkg::ERR_NO_STAR;
            end else begin
                code = rrf_pkg::ERR_NONE;
            end
            result_next.fault_code    = code;
            result_next.record_status = (code == rrf_pkg::ERR_NONE) ?
                                        rrf_pkg::STATUS_VALID : rrf_pkg::STATUS_INVALID;
            phase_next     = PH_STAR;
            acc_next       = '0;
            neg_next       = 1'b0;
            has_next       = 1'b0;
            args_left_next = '0;
            cur_arg_next   = '0;
            bulk_left_next = '0;
            bulk_held_next = '0;
            err_next       = rrf_pkg::ERR_NONE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_STAR;
            acc_reg       <= '0;
            neg_reg       <= 1'b0;
            has_reg       <= 1'b0;
            args_left_reg <= '0;
            cur_arg_reg   <= '0;
            bulk_left_reg <= '0;
            bulk_held_reg <= '0;
            err_reg       <= rrf_pkg::ERR_NONE;
            result_reg    <= '0;
        end else if (step_en) begin
            phase_reg     <= phase_next;
            acc_reg       <= acc_next;
            neg_reg       <= neg_next;
            has_reg       <= has_next;
            args_left_reg <= args_left_next;
            cur_arg_reg   <= cur_arg_next;
            bulk_left_reg <= bulk_left_next;
            bulk_held_reg <= bulk_held_next;
            err_reg       <= err_next;
            result_reg    <= result_next;
        end
    end

endmodule

/* src/resp_request_framer.sv */
// Top level of the RESP request framer: request buffer, result valid and configuration.
//
//  channel   direction  handshake          payload
//  s_        in         s_valid / s_ready  rrf_pkg::in_t  (in_byte, record_end)
//  m_        out        m_valid / m_ready  rrf_pkg::out_t (kind .. fault_code)
//  cfg_      in         cfg_we             cfg_idx, cfg_wdata
//
// One request per cycle sustained while m_ready stays high; a taken request is stepped
// from the request register through the framer into the result register once that is
// free. A stalled result holds while one more request waits in the request register;
// s_ready stays low until m_ready frees the result register.
// Synchronous active-low reset returns the framer to expecting the array marker and
// restores the configuration defaults; no clearing pass is needed.
module resp_request_framer #(
    parameter int ARG_LIMIT    = 1024,
    parameter int LENGTH_BOUND = 1048576
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  rrf_pkg::in_t                 s_data,
    output logic                         m_valid,
    input  logic                         m_ready,
    output rrf_pkg::out_t                m_data,
    input  logic                         cfg_we,
    input  logic                         cfg_idx,
    input  logic [rrf_pkg::CFG_W-1:0]    cfg_wdata
);

    logic           in_valid_reg, in_valid_next;
    rrf_pkg::in_t   in_item_reg;
    logic           out_valid_reg, out_valid_next;
    logic [10:0]    max_arguments_reg;
    logic [20:0]    max_bulk_length_reg;
    logic           advance;
    logic           s_take;

    // move the buffered request into the framer when the result slot frees up
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign s_take  = s_valid && s_ready;
    assign m_valid = out_valid_reg;

    always_comb begin
        in_valid_next  = s_take ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
        out_valid_next = advance ? 1'b1 : (m_ready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg        <= 1'b0;
            out_valid_reg       <= 1'b0;
            max_arguments_reg   <= rrf_pkg::MAX_ARGUMENTS_RESET;
            max_bulk_length_reg <= rrf_pkg::MAX_BULK_LENGTH_RESET;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we) begin
                unique case (cfg_idx)
                    rrf_pkg::REG_MAX_ARGUMENTS:   max_arguments_reg   <= cfg_wdata[10:0];
                    rrf_pkg::REG_MAX_BULK_LENGTH: max_bulk_length_reg <= cfg_wdata;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_take) begin
            in_item_reg <= s_data;
        end
    end

    rrf_core #(
        .ARG_LIMIT    (ARG_LIMIT),
        .LENGTH_BOUND (LENGTH_BOUND)
    ) u_core (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .step_en         (advance),
        .item            (in_item_reg),
        .max_arguments   (max_arguments_reg),
        .max_bulk_length (max_bulk_length_reg),
        .result_reg      (m_data)
    );

endmodule
